// ===== design/sunocc_pkg.sv =====
// shared types, constants and the microcode table of the sun occlusion test
package sunocc_pkg;

   localparam int COORD_BITS_DEF  = 32;
   localparam int RADIUS_BITS_DEF = 24;
   localparam int OPCODE_W        = 2;
   localparam int DIG             = 16;   // multiplier digit width
   localparam int NSTEPS          = 14;
   localparam int STEP_W          = 4;

   typedef enum logic [OPCODE_W-1:0] {
      OP_OBSERVER = 2'd0,
      OP_SUN      = 2'd1,
      OP_BODY     = 2'd2,
      OP_NONE     = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_MUL,
      ST_ACC,
      ST_FIN
   } state_type;

   typedef enum logic [3:0] {
      SRC_D0,
      SRC_D1,
      SRC_D2,
      SRC_M0,
      SRC_M1,
      SRC_M2,
      SRC_CR0,
      SRC_CR1,
      SRC_CR2,
      SRC_DSQ,
      SRC_RR,
      SRC_RAD
   } src_type;

   typedef enum logic [2:0] {
      DST_NONE,
      DST_CR0,
      DST_CR1,
      DST_CR2,
      DST_LHS,
      DST_DSQ,
      DST_RR,
      DST_CMP
   } dst_type;

   typedef struct packed {
      src_type a;
      src_type b;
      logic    clr;
      logic    sub;
      dst_type dst;
   } step_type;

   // cross product, its squared length, |d|^2, r^2, then r^2 * |d|^2 against it
   function automatic step_type step_info(input logic [STEP_W-1:0] idx);
      step_type s;
      s = '{a: SRC_D0, b: SRC_D0, clr: 1'b1, sub: 1'b0, dst: DST_NONE};
      unique case (idx)
         4'd0:  s = '{a: SRC_D1,  b: SRC_M2,  clr: 1'b1, sub: 1'b0, dst: DST_NONE};
         4'd1:  s = '{a: SRC_D2,  b: SRC_M1,  clr: 1'b0, sub: 1'b1, dst: DST_CR0};
         4'd2:  s = '{a: SRC_D2,  b: SRC_M0,  clr: 1'b1, sub: 1'b0, dst: DST_NONE};
         4'd3:  s = '{a: SRC_D0,  b: SRC_M2,  clr: 1'b0, sub: 1'b1, dst: DST_CR1};
         4'd4:  s = '{a: SRC_D0,  b: SRC_M1,  clr: 1'b1, sub: 1'b0, dst: DST_NONE};
         4'd5:  s = '{a: SRC_D1,  b: SRC_M0,  clr: 1'b0, sub: 1'b1, dst: DST_CR2};
         4'd6:  s = '{a: SRC_CR0, b: SRC_CR0, clr: 1'b1, sub: 1'b0, dst: DST_NONE};
         4'd7:  s = '{a: SRC_CR1, b: SRC_CR1, clr: 1'b0, sub: 1'b0, dst: DST_NONE};
         4'd8:  s = '{a: SRC_CR2, b: SRC_CR2, clr: 1'b0, sub: 1'b0, dst: DST_LHS};
         4'd9:  s = '{a: SRC_D0,  b: SRC_D0,  clr: 1'b1, sub: 1'b0, dst: DST_NONE};
         4'd10: s = '{a: SRC_D1,  b: SRC_D1,  clr: 1'b0, sub: 1'b0, dst: DST_NONE};
         4'd11: s = '{a: SRC_D2,  b: SRC_D2,  clr: 1'b0, sub: 1'b0, dst: DST_DSQ};
         4'd12: s = '{a: SRC_RAD, b: SRC_RAD, clr: 1'b1, sub: 1'b0, dst: DST_RR};
         4'd13: s = '{a: SRC_DSQ, b: SRC_RR,  clr: 1'b1, sub: 1'b0, dst: DST_CMP};
         default: s = '{a: SRC_D0, b: SRC_D0, clr: 1'b1, sub: 1'b0, dst: DST_NONE};
      endcase
      return s;
   endfunction

endpackage

// ===== design/sun_occlusion_line_sphere_test_core.sv =====
// sun occlusion test: observer-sun line against a run of spheres, shared multiplier
//
//   channel | direction | ports                                          | handshake
//   req     | in        | opcode, pos_x/y/z, body_radius, last           | valid / stall
//   rsp     | out       | blocked                                        | valid / stall
//
// a position or unused item leaves the core idle; a body runs each microcode step of the
// package table as a load, NDIG = ceil(max(2*COORD_BITS+4, 2*RADIUS_BITS) / 16) digit
// multiplies and an accumulate, in the one shared operand-by-16-bit multiplier and its
// accumulator. an item marked last then hands its result to the output register once it is free.
// reset clears the stored positions, the blocked flag and the output valid flag.
// req_stall is high whenever the core is not idle: while a body is worked on and while a
// result is handed to the output register or waits for it to free up.
module sun_occlusion_line_sphere_test_core #(
   parameter int COORD_BITS  = sunocc_pkg::COORD_BITS_DEF,
   parameter int RADIUS_BITS = sunocc_pkg::RADIUS_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [sunocc_pkg::OPCODE_W-1:0]     req_opcode,
   input  logic signed [COORD_BITS-1:0]        req_pos_x,
   input  logic signed [COORD_BITS-1:0]        req_pos_y,
   input  logic signed [COORD_BITS-1:0]        req_pos_z,
   input  logic [RADIUS_BITS-1:0]              req_body_radius,
   input  logic                                req_last,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_blocked
);

   localparam int DW    = COORD_BITS + 1;
   localparam int CRW   = 2 * COORD_BITS + 3;
   localparam int DSQW  = 2 * COORD_BITS + 4;
   localparam int RRW   = 2 * RADIUS_BITS;
   localparam int OPW   = (DSQW > RRW) ? DSQW : RRW;
   localparam int SVW   = OPW + 1;
   localparam int DIG   = sunocc_pkg::DIG;
   localparam int NDIG  = (OPW + DIG - 1) / DIG;
   localparam int BPAD  = NDIG * DIG;
   localparam int PRW   = OPW + BPAD;
   localparam int ACW   = PRW + 2;
   localparam int CNT_W = $clog2(NDIG + 1);
   localparam int STW   = sunocc_pkg::STEP_W;

   sunocc_pkg::state_type state_ff, state_in;
   sunocc_pkg::step_type  step_cur;

   logic signed [COORD_BITS-1:0] obs_ff [3];
   logic signed [COORD_BITS-1:0] obs_in [3];
   logic signed [COORD_BITS-1:0] sun_ff [3];
   logic signed [COORD_BITS-1:0] sun_in [3];
   logic signed [COORD_BITS-1:0] req_pos [3];
   logic signed [DW-1:0]         d_ff   [3];
   logic signed [DW-1:0]         d_in   [3];
   logic signed [DW-1:0]         m_ff   [3];
   logic signed [DW-1:0]         m_in   [3];
   logic signed [CRW-1:0]        cr_ff  [3];
   logic signed [CRW-1:0]        cr_in  [3];
   logic [DSQW-1:0]              dsq_ff, dsq_in;
   logic [RRW-1:0]               rr_ff, rr_in;
   logic [RADIUS_BITS-1:0]       rad_ff, rad_in;
   logic [PRW-1:0]               lhs_ff, lhs_in;

   logic [OPW-1:0]               a_mag_ff, a_mag_in;
   logic [BPAD-1:0]              b_sh_ff, b_sh_in;
   logic                         neg_ff, neg_in;
   logic [OPW+DIG-1:0]           pp_ff, pp_in;
   logic [PRW-1:0]               prod_ff, prod_in;
   logic signed [ACW-1:0]        acc_ff, acc_in;
   logic signed [ACW-1:0]        acc_base;
   logic signed [SVW-1:0]        a_sv, b_sv;
   logic [OPW-1:0]               a_mag, b_mag;

   logic [STW-1:0]               step_ff, step_in;
   logic [CNT_W-1:0]             cnt_ff, cnt_in;
   logic                         last_ff, last_in;
   logic                         blocked_acc_ff, blocked_acc_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_blocked_ff, rsp_blocked_in;

   logic                         req_fire;
   logic                         fin_emit;
   logic                         last_step;
   sunocc_pkg::op_type           req_op;

   // operand fetch, signed view of every source
   function automatic logic signed [SVW-1:0] fetch(
      input sunocc_pkg::src_type    src,
      input logic signed [DW-1:0]   d0, d1, d2, m0, m1, m2,
      input logic signed [CRW-1:0]  c0, c1, c2,
      input logic [DSQW-1:0]        dsq,
      input logic [RRW-1:0]         rr,
      input logic [RADIUS_BITS-1:0] rad
   );
      logic signed [SVW-1:0] v;
      v = '0;
      unique case (src)
         sunocc_pkg::SRC_D0:  v = SVW'(d0);
         sunocc_pkg::SRC_D1:  v = SVW'(d1);
         sunocc_pkg::SRC_D2:  v = SVW'(d2);
         sunocc_pkg::SRC_M0:  v = SVW'(m0);
         sunocc_pkg::SRC_M1:  v = SVW'(m1);
         sunocc_pkg::SRC_M2:  v = SVW'(m2);
         sunocc_pkg::SRC_CR0: v = SVW'(c0);
         sunocc_pkg::SRC_CR1: v = SVW'(c1);
         sunocc_pkg::SRC_CR2: v = SVW'(c2);
         sunocc_pkg::SRC_DSQ: v = $signed({{(SVW-DSQW){1'b0}}, dsq});
         sunocc_pkg::SRC_RR:  v = $signed({{(SVW-RRW){1'b0}}, rr});
         sunocc_pkg::SRC_RAD: v = $signed({{(SVW-RADIUS_BITS){1'b0}}, rad});
         default:             v = '0;
      endcase
      return v;
   endfunction

   assign req_pos[0] = req_pos_x;
   assign req_pos[1] = req_pos_y;
   assign req_pos[2] = req_pos_z;
   assign req_op     = sunocc_pkg::op_type'(req_opcode);
   assign step_cur   = sunocc_pkg::step_info(step_ff);
   assign last_step  = (step_ff == STW'(sunocc_pkg::NSTEPS - 1));

   assign a_sv  = fetch(step_cur.a, d_ff[0], d_ff[1], d_ff[2], m_ff[0], m_ff[1], m_ff[2],
                        cr_ff[0], cr_ff[1], cr_ff[2], dsq_ff, rr_ff, rad_ff);
   assign b_sv  = fetch(step_cur.b, d_ff[0], d_ff[1], d_ff[2], m_ff[0], m_ff[1], m_ff[2],
                        cr_ff[0], cr_ff[1], cr_ff[2], dsq_ff, rr_ff, rad_ff);
   assign a_mag = a_sv[SVW-1] ? OPW'(-a_sv) : OPW'(a_sv);
   assign b_mag = b_sv[SVW-1] ? OPW'(-b_sv) : OPW'(b_sv);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sunocc_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (req_op == sunocc_pkg::OP_BODY) state_in = sunocc_pkg::ST_LOAD;
               else if (req_last) state_in = sunocc_pkg::ST_FIN;
            end
         end
         sunocc_pkg::ST_LOAD: state_in = sunocc_pkg::ST_MUL;
         sunocc_pkg::ST_MUL: begin
            if (cnt_ff == CNT_W'(NDIG)) state_in = sunocc_pkg::ST_ACC;
         end
         sunocc_pkg::ST_ACC: begin
            if (!last_step) state_in = sunocc_pkg::ST_LOAD;
            else if (last_ff) state_in = sunocc_pkg::ST_FIN;
            else state_in = sunocc_pkg::ST_IDLE;
         end
         sunocc_pkg::ST_FIN: begin
            if (!rsp_valid_ff || !rsp_stall) state_in = sunocc_pkg::ST_IDLE;
         end
         default: state_in = sunocc_pkg::ST_IDLE;
      endcase
   end

   // handshake outputs
   always_comb begin
      req_stall = (state_ff != sunocc_pkg::ST_IDLE);
      req_fire  = req_valid && (state_ff == sunocc_pkg::ST_IDLE);
      fin_emit  = (state_ff == sunocc_pkg::ST_FIN) && (!rsp_valid_ff || !rsp_stall);
   end

   // datapath and bookkeeping
   always_comb begin
      obs_in         = obs_ff;
      sun_in         = sun_ff;
      d_in           = d_ff;
      m_in           = m_ff;
      cr_in          = cr_ff;
      dsq_in         = dsq_ff;
      rr_in          = rr_ff;
      rad_in         = rad_ff;
      lhs_in         = lhs_ff;
      a_mag_in       = a_mag_ff;
      b_sh_in        = b_sh_ff;
      neg_in         = neg_ff;
      pp_in          = pp_ff;
      prod_in        = prod_ff;
      acc_in         = acc_ff;
      step_in        = step_ff;
      cnt_in         = cnt_ff;
      last_in        = last_ff;
      blocked_acc_in = blocked_acc_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_blocked_in = rsp_blocked_ff;
      acc_base       = step_cur.clr ? '0 : acc_ff;

      if (req_fire) begin
         last_in = req_last;
         step_in = '0;
         unique case (req_op)
            sunocc_pkg::OP_OBSERVER: obs_in = req_pos;
            sunocc_pkg::OP_SUN:      sun_in = req_pos;
            sunocc_pkg::OP_BODY: begin
               rad_in = req_body_radius;
               for (int k = 0; k < 3; k++) begin
                  d_in[k] = DW'(sun_ff[k]) - DW'(obs_ff[k]);
                  m_in[k] = DW'(obs_ff[k]) - DW'(req_pos[k]);
               end
            end
            sunocc_pkg::OP_NONE: ;
            default: ;
         endcase
      end

      if (state_ff == sunocc_pkg::ST_LOAD) begin
         a_mag_in = a_mag;
         b_sh_in  = BPAD'(b_mag);
         neg_in   = a_sv[SVW-1] ^ b_sv[SVW-1] ^ step_cur.sub;
         prod_in  = '0;
         cnt_in   = '0;
      end

      // one 16-bit digit of b per cycle, most significant first, product registered
      if (state_ff == sunocc_pkg::ST_MUL) begin
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff != CNT_W'(NDIG)) begin
            pp_in   = (OPW+DIG)'(a_mag_ff) * (OPW+DIG)'(b_sh_ff[BPAD-1 -: DIG]);
            b_sh_in = b_sh_ff << DIG;
         end
         if (cnt_ff != '0) prod_in = (prod_ff << DIG) + PRW'(pp_ff);
      end

      if (state_ff == sunocc_pkg::ST_ACC) begin
         acc_in  = neg_ff ? acc_base - $signed({2'b00, prod_ff})
                          : acc_base + $signed({2'b00, prod_ff});
         step_in = step_ff + 1'b1;
         unique case (step_cur.dst)
            sunocc_pkg::DST_NONE: ;
            sunocc_pkg::DST_CR0:  cr_in[0] = CRW'(acc_in);
            sunocc_pkg::DST_CR1:  cr_in[1] = CRW'(acc_in);
            sunocc_pkg::DST_CR2:  cr_in[2] = CRW'(acc_in);
            sunocc_pkg::DST_LHS:  lhs_in   = PRW'(acc_in);
            sunocc_pkg::DST_DSQ:  dsq_in   = DSQW'(acc_in);
            sunocc_pkg::DST_RR:   rr_in    = RRW'(acc_in);
            // tangency counts as a hit
            sunocc_pkg::DST_CMP:  blocked_acc_in = blocked_acc_ff | (lhs_ff <= prod_ff);
            default: ;
         endcase
      end

      if (fin_emit) begin
         rsp_valid_in   = 1'b1;
         rsp_blocked_in = blocked_acc_ff;
         blocked_acc_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= sunocc_pkg::ST_IDLE;
         obs_ff         <= '{default: '0};
         sun_ff         <= '{default: '0};
         blocked_acc_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         step_ff        <= '0;
         cnt_ff         <= '0;
         last_ff        <= 1'b0;
      end else begin
         state_ff       <= state_in;
         obs_ff         <= obs_in;
         sun_ff         <= sun_in;
         blocked_acc_ff <= blocked_acc_in;
         rsp_valid_ff   <= rsp_valid_in;
         step_ff        <= step_in;
         cnt_ff         <= cnt_in;
         last_ff        <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      d_ff           <= d_in;
      m_ff           <= m_in;
      cr_ff          <= cr_in;
      dsq_ff         <= dsq_in;
      rr_ff          <= rr_in;
      rad_ff         <= rad_in;
      lhs_ff         <= lhs_in;
      a_mag_ff       <= a_mag_in;
      b_sh_ff        <= b_sh_in;
      neg_ff         <= neg_in;
      pp_ff          <= pp_in;
      prod_ff        <= prod_in;
      acc_ff         <= acc_in;
      rsp_blocked_ff <= rsp_blocked_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_blocked = rsp_blocked_ff;

endmodule

// ===== design/sunocc_checker.sv =====
// port-level checker for the sun occlusion test, bound to the top level
module sunocc_checker #(
   parameter int COORD_BITS  = sunocc_pkg::COORD_BITS_DEF,
   parameter int RADIUS_BITS = sunocc_pkg::RADIUS_BITS_DEF
) (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_stall,
   input logic [sunocc_pkg::OPCODE_W-1:0] req_opcode,
   input logic signed [COORD_BITS-1:0]    req_pos_x,
   input logic signed [COORD_BITS-1:0]    req_pos_y,
   input logic signed [COORD_BITS-1:0]    req_pos_z,
   input logic [RADIUS_BITS-1:0]          req_body_radius,
   input logic                            req_last,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input logic                            rsp_blocked
);

   logic req_fire;
   assign req_fire = req_valid && !req_stall;

   // a held response keeps its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_blocked))
      else $error("response dropped or changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response present right after reset");

   // a body keeps the shared multiplier busy
   a_body_busy: assert property (@(posedge clock) disable iff (reset)
      req_fire && (req_opcode == sunocc_pkg::OP_BODY) |=> req_stall)
      else $error("request taken straight after a body");

   a_last_busy: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_last |=> req_stall)
      else $error("request taken before result of a closing request");

   // no response appears out of a request that does not close a query
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      req_fire && !req_last && (req_opcode != sunocc_pkg::OP_BODY) && !rsp_valid
      |=> !rsp_valid)
      else $error("response without a closing request");

endmodule

bind sun_occlusion_line_sphere_test_core sunocc_checker #(
   .COORD_BITS  (COORD_BITS),
   .RADIUS_BITS (RADIUS_BITS)
) u_sunocc_checker (.*);

// ===== tb/sv/tb.sv =====
// self-checking testbench for the sun occlusion line-sphere test core
module tb;
   import sunocc_pkg::*;

   localparam int CW           = COORD_BITS_DEF;
   localparam int RW           = RADIUS_BITS_DEF;
   localparam int ITEMS_TARGET = 950;
   localparam logic signed [CW-1:0] C_MAX = {1'b0, {(CW-1){1'b1}}};
   localparam logic signed [CW-1:0] C_MIN = {1'b1, {(CW-1){1'b0}}};

   typedef struct {
      op_type               op;
      logic signed [CW-1:0] pos_x;
      logic signed [CW-1:0] pos_y;
      logic signed [CW-1:0] pos_z;
      logic [RW-1:0]        radius;
      logic                 last;
   } occ_request_t;

   typedef enum int {
      SPREAD_FULL,
      SPREAD_NEAR_ORIGIN,
      SPREAD_NEAR_LINE
   } spread_t;

   class occlusion_scoreboard;
      logic signed [CW-1:0] observer_pos [3];
      logic signed [CW-1:0] sun_pos [3];
      bit                   blocked_acc;
      bit                   expected_blocked [$];
      int                   errors;
      int                   checked;
      int                   hits;

      function new();
         observer_pos = '{0, 0, 0};
         sun_pos      = '{0, 0, 0};
         blocked_acc  = 1'b0;
         errors       = 0;
         checked      = 0;
         hits         = 0;
      endfunction

      // |d x m|^2 <= r^2 |d|^2 with d = sun - observer, m = observer - centre
      function bit line_meets_sphere(occ_request_t rq);
         logic signed [CW-1:0]  centre [3];
         logic signed [255:0]   ob, so, ce;
         logic signed [255:0]   d [3];
         logic signed [255:0]   m [3];
         logic signed [255:0]   cr [3];
         logic signed [255:0]   cross_sq, dir_sq, rad;
         int                    k;
         centre = '{rq.pos_x, rq.pos_y, rq.pos_z};
         for (k = 0; k < 3; k++) begin
            ob   = observer_pos[k];
            so   = sun_pos[k];
            ce   = centre[k];
            d[k] = so - ob;
            m[k] = ob - ce;
         end
         cr[0]    = d[1] * m[2] - d[2] * m[1];
         cr[1]    = d[2] * m[0] - d[0] * m[2];
         cr[2]    = d[0] * m[1] - d[1] * m[0];
         cross_sq = cr[0] * cr[0] + cr[1] * cr[1] + cr[2] * cr[2];
         dir_sq   = d[0] * d[0] + d[1] * d[1] + d[2] * d[2];
         rad      = {{(256-RW){1'b0}}, rq.radius};
         return cross_sq <= rad * rad * dir_sq;
      endfunction

      function void note_request(occ_request_t rq);
         case (rq.op)
            OP_OBSERVER: observer_pos = '{rq.pos_x, rq.pos_y, rq.pos_z};
            OP_SUN:      sun_pos      = '{rq.pos_x, rq.pos_y, rq.pos_z};
            OP_BODY: begin
               if (line_meets_sphere(rq))
                  blocked_acc = 1'b1;
            end
            default: ;
         endcase
         if (rq.last) begin
            expected_blocked.push_back(blocked_acc);
            blocked_acc = 1'b0;
         end
      endfunction

      function void check_blocked(logic actual);
         bit want;
         if (expected_blocked.size() == 0) begin
            $display("%0t: response with none expected, blocked=%0b", $time, actual);
            errors++;
            return;
         end
         want = expected_blocked.pop_front();
         checked++;
         if (want)
            hits++;
         if (actual !== want) begin
            $display("%0t: blocked mismatch, expected %0b, got %0b", $time, want, actual);
            errors++;
         end
      endfunction

      function int pending();
         return expected_blocked.size();
      endfunction
   endclass

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_stall;
   logic [OPCODE_W-1:0]        req_opcode;
   logic signed [CW-1:0]       req_pos_x;
   logic signed [CW-1:0]       req_pos_y;
   logic signed [CW-1:0]       req_pos_z;
   logic [RW-1:0]              req_body_radius;
   logic                       req_last;
   logic                       rsp_valid;
   logic                       rsp_stall;
   logic                       rsp_blocked;

   occlusion_scoreboard        sb;
   int                         req_idle_pct;
   int                         rsp_idle_pct;
   int                         rsp_hold_cycles;
   int                         requests_sent;
   int                         queries_sent;
   logic signed [CW-1:0]       obs_seen [3];
   logic signed [CW-1:0]       sun_seen [3];

   sun_occlusion_line_sphere_test_core u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_opcode      (req_opcode),
      .req_pos_x       (req_pos_x),
      .req_pos_y       (req_pos_y),
      .req_pos_z       (req_pos_z),
      .req_body_radius (req_body_radius),
      .req_last        (req_last),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_blocked     (rsp_blocked)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   function automatic occ_request_t make_request(op_type op, logic signed [CW-1:0] x,
                                                 logic signed [CW-1:0] y,
                                                 logic signed [CW-1:0] z,
                                                 logic [RW-1:0] r, logic last);
      occ_request_t rq;
      rq.op     = op;
      rq.pos_x  = x;
      rq.pos_y  = y;
      rq.pos_z  = z;
      rq.radius = r;
      rq.last   = last;
      return rq;
   endfunction

   function automatic logic signed [CW-1:0] pick_coord(spread_t sp,
                                                       logic signed [CW-1:0] anchor);
      logic signed [CW-1:0] delta;
      delta = CW'($urandom >> $urandom_range(1, 31));
      if ($urandom_range(0, 1) == 1)
         delta = -delta;
      case (sp)
         SPREAD_FULL:        return CW'($urandom);
         SPREAD_NEAR_ORIGIN: return CW'($urandom_range(0, 4000) - 2000);
         default:            return anchor + delta;
      endcase
   endfunction

   function automatic logic [RW-1:0] pick_radius(spread_t sp);
      case (sp)
         SPREAD_FULL:        return RW'($urandom_range(0, (1 << RW) - 1));
         SPREAD_NEAR_ORIGIN: return RW'($urandom_range(0, 2000));
         default:            return RW'($urandom_range(0, (1 << RW) - 1) >>
                                        $urandom_range(0, RW - 1));
      endcase
   endfunction

   task automatic send_request(input occ_request_t rq);
      int gap;
      if (req_idle_pct != 0 && $urandom_range(0, 99) < req_idle_pct) begin
         gap = $urandom_range(1, 12);
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid       <= 1'b1;
      req_opcode      <= rq.op;
      req_pos_x       <= rq.pos_x;
      req_pos_y       <= rq.pos_y;
      req_pos_z       <= rq.pos_z;
      req_body_radius <= rq.radius;
      req_last        <= rq.last;
      do @(posedge clock); while (req_stall);
      sb.note_request(rq);
      if (rq.op != OP_NONE || rq.last)
         requests_sent++;
      if (rq.last)
         queries_sent++;
      if (rq.op == OP_OBSERVER)
         obs_seen = '{rq.pos_x, rq.pos_y, rq.pos_z};
      if (rq.op == OP_SUN)
         sun_seen = '{rq.pos_x, rq.pos_y, rq.pos_z};
   endtask

   // one query: positions (sometimes left out), then a run of up to four bodies, now and then a position between them
   task automatic run_query();
      occ_request_t         rq;
      spread_t              sp;
      spread_t              pos_sp;
      int                   nbodies;
      int                   i;
      logic signed [CW-1:0] anchor [3];
      sp      = spread_t'($urandom_range(0, 2));
      pos_sp  = (sp == SPREAD_NEAR_LINE) ? SPREAD_FULL : sp;
      nbodies = $urandom_range(0, 4);
      if ($urandom_range(0, 9) != 0)
         send_request(make_request(OP_OBSERVER, pick_coord(pos_sp, 0), pick_coord(pos_sp, 0),
                                   pick_coord(pos_sp, 0), RW'($urandom), 1'b0));
      if ($urandom_range(0, 9) != 0)
         send_request(make_request(OP_SUN, pick_coord(pos_sp, 0), pick_coord(pos_sp, 0),
                                   pick_coord(pos_sp, 0), RW'($urandom), 1'b0));
      for (i = 0; i < nbodies; i++) begin
         if ($urandom_range(0, 11) == 0)
            send_request(make_request(op_type'($urandom_range(0, 1)), pick_coord(pos_sp, 0),
                                      pick_coord(pos_sp, 0), pick_coord(pos_sp, 0),
                                      RW'($urandom), 1'b0));
         anchor = ($urandom_range(0, 1) == 1) ? obs_seen : sun_seen;
         rq = make_request(OP_BODY, pick_coord(sp, anchor[0]), pick_coord(sp, anchor[1]),
                           pick_coord(sp, anchor[2]), pick_radius(sp), i == nbodies - 1);
         send_request(rq);
      end
      // an empty query ends on a random item: a position, a body or an unused item
      if (nbodies == 0)
         send_request(make_request(op_type'($urandom_range(0, 3)), pick_coord(pos_sp, 0),
                                   pick_coord(pos_sp, 0), pick_coord(pos_sp, 0),
                                   RW'($urandom), 1'b1));
   endtask

   // receiving side: random stall bursts plus one long hold-off
   initial begin
      int stall_left;
      rsp_stall  = 1'b0;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (rsp_hold_cycles > 0) begin
            rsp_hold_cycles--;
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (rsp_idle_pct != 0 && $urandom_range(0, 99) < rsp_idle_pct) begin
            stall_left = $urandom_range(1, 12) - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
         @(posedge clock);
         if (rsp_valid && !rsp_stall)
            sb.check_blocked(rsp_blocked);
      end
   end

   initial begin
      sb              = new();
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_opcode      = OP_NONE;
      req_pos_x       = '0;
      req_pos_y       = '0;
      req_pos_z       = '0;
      req_body_radius = '0;
      req_last        = 1'b0;
      req_idle_pct    = 0;
      rsp_idle_pct    = 0;
      rsp_hold_cycles = 0;
      requests_sent   = 0;
      queries_sent    = 0;
      obs_seen        = '{0, 0, 0};
      sun_seen        = '{0, 0, 0};
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty query right after reset, unused opcode ignored and then ending a query
      send_request(make_request(OP_OBSERVER, 0, 0, 0, 0, 1'b1));
      send_request(make_request(OP_NONE, -1, -1, -1, '1, 1'b0));
      send_request(make_request(OP_NONE, C_MAX, C_MIN, C_MAX, '1, 1'b1));
      // tangency blocks, one km less does not
      send_request(make_request(OP_OBSERVER, 0, 0, 0, 0, 1'b0));
      send_request(make_request(OP_SUN, 100, 0, 0, 0, 1'b0));
      send_request(make_request(OP_BODY, 0, 5, 0, 5, 1'b0));
      send_request(make_request(OP_BODY, 0, 5, 0, 4, 1'b1));
      send_request(make_request(OP_BODY, 0, 5, 0, 4, 1'b1));
      // observer on the sun: every body blocks
      send_request(make_request(OP_SUN, 0, 0, 0, 0, 1'b0));
      send_request(make_request(OP_BODY, C_MAX, C_MIN, C_MAX, 0, 1'b1));
      // corner to corner of the coordinate range
      send_request(make_request(OP_OBSERVER, C_MIN, C_MIN, C_MIN, 0, 1'b0));
      send_request(make_request(OP_SUN, C_MAX, C_MAX, C_MAX, '1, 1'b0));
      send_request(make_request(OP_BODY, 0, 0, 0, 0, 1'b0));
      send_request(make_request(OP_BODY, C_MAX, C_MIN, 0, '1, 1'b1));
      // sun moves mid-query, query ends on an observer item
      send_request(make_request(OP_OBSERVER, 0, 0, 0, 0, 1'b0));
      send_request(make_request(OP_SUN, 0, 0, 1000, 0, 1'b0));
      send_request(make_request(OP_BODY, 500, 0, 0, 100, 1'b0));
      send_request(make_request(OP_SUN, 1000, 0, 0, 0, 1'b0));
      send_request(make_request(OP_BODY, 500, 50, 0, 100, 1'b0));
      send_request(make_request(OP_OBSERVER, 0, 0, 5000, 0, 1'b1));
      send_request(make_request(OP_BODY, C_MIN, C_MAX, C_MIN, '1, 1'b1));

      // long receiver hold-off while requests keep coming
      rsp_hold_cycles = 1500;
      while (requests_sent < ITEMS_TARGET) begin
         if (requests_sent > ITEMS_TARGET * 4 / 5) begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end else if ($urandom_range(0, 2) == 0) begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end else begin
            req_idle_pct = 25;
            rsp_idle_pct = 25;
         end
         if ($urandom_range(0, 9) == 0)
            send_request(make_request(op_type'($urandom_range(0, 3)), CW'($urandom),
                                      CW'($urandom), CW'($urandom), RW'($urandom),
                                      1'($urandom_range(0, 1))));
         else
            run_query();
      end
      @(negedge clock);
      req_valid <= 1'b0;

      while (sb.pending() != 0)
         @(posedge clock);
      repeat (200) @(posedge clock);

      $display("sent %0d requests over %0d queries, including corner and empty cases",
               requests_sent, queries_sent);
      $display("checked %0d answers, %0d of them blocked", sb.checked, sb.hits);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("timeout with %0d answers outstanding", sb.pending());
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
